@@ src/rct_pkg.sv @@
// ----------------------------------------------------------------------------
// rct_pkg: shared types and constants of the three-rotor cipher
// Operation and configuration codes and the fixed field widths of the items.
// ----------------------------------------------------------------------------
`default_nettype none

package rct_pkg;

  // Fixed field widths of the items and registers.
  localparam int SYM_W   = 5;
  localparam int SEL_W   = 2;
  localparam int POS_W   = 7;
  localparam int THR_W   = 5;
  localparam int CFG_A_W = 2;

  localparam logic [POS_W-1:0] POS_MAX      = 7'd127;
  localparam logic [THR_W-1:0] THRESH_RESET = 5'd4;

  typedef enum logic [1:0] {
    OP_ENCRYPT = 2'd0,
    OP_DECRYPT = 2'd1,
    OP_LOAD    = 2'd2,
    OP_SET_POS = 2'd3
  } op_t;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_START1 = 2'd0,
    CFG_START2 = 2'd1,
    CFG_START3 = 2'd2,
    CFG_THRESH = 2'd3
  } cfg_idx_t;

endpackage

`default_nettype wire

@@ src/rct_if.sv @@
// ----------------------------------------------------------------------------
// rct_if: item channels of the three-rotor cipher
// Valid/ready channels for command items and for result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface rct_in_if;
  logic                      valid;
  logic                      ready;
  rct_pkg::op_t              operation;
  logic [rct_pkg::SYM_W-1:0] symbol;
  logic                      start_message;
  logic [rct_pkg::SEL_W-1:0] rotor_select;
  logic [rct_pkg::SYM_W-1:0] wiring_index;
  logic [rct_pkg::SYM_W-1:0] wiring_value;

  modport source (output valid, operation, symbol, start_message, rotor_select,
                  wiring_index, wiring_value, input ready);
  modport sink   (input valid, operation, symbol, start_message, rotor_select,
                  wiring_index, wiring_value, output ready);
endinterface

interface rct_out_if;
  logic                      valid;
  logic                      ready;
  logic [rct_pkg::SYM_W-1:0] out_symbol;
  logic                      error;

  modport source (output valid, out_symbol, error, input ready);
  modport sink   (input valid, out_symbol, error, output ready);
endinterface

`default_nettype wire

@@ src/rotor_cipher_three_rotor_unit.sv @@
// ----------------------------------------------------------------------------
// rotor_cipher_three_rotor_unit: rotor substitution cipher without reflector
// Enciphers and deciphers symbols through loadable rotor wirings held in
// synchronous memory banks, one rotor stage per pipeline stage.
// ----------------------------------------------------------------------------
// An item is registered in each rotor stage in turn and then in the output register.
// Throughput: one item per cycle while the output is taken; each rotor stage does one
// registered read of its wiring bank per cycle when it moves.
// Reset (rst_n low, synchronous): empties the pipeline, clears the rotor
// offsets and the message position, start positions to 0, threshold to 4.
// Wiring banks are not cleared; they are undefined until loaded.
`default_nettype none

module rotor_cipher_three_rotor_unit #(
  parameter int SYMBOL_COUNT = 27,
  parameter int ROTOR_COUNT  = 3
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  rct_in_if.sink                           in_ch,
  rct_out_if.source                        out_ch,
  input  wire logic                        cfg_we,
  input  wire rct_pkg::cfg_idx_t           cfg_index,
  input  wire logic [rct_pkg::SYM_W-1:0]   cfg_wdata
);

  localparam int SW = rct_pkg::SYM_W;
  // Address width of one wiring bank.
  localparam int AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam logic [SW:0] SC_X = (SW+1)'(SYMBOL_COUNT);

  // Control and payload that travel with an item from stage to stage. The
  // offsets are a snapshot taken when the item is accepted, so the live
  // offsets can move on for the items that follow.
  typedef struct packed {
    rct_pkg::op_t                    op;
    logic                            err;
    logic                            ld_ok;
    logic [rct_pkg::SEL_W-1:0]       sel;
    logic [SW-1:0]                   idx;
    logic [SW-1:0]                   val;
    logic [ROTOR_COUNT-1:0][SW-1:0]  off;
  } stg_t;

  // Modular helpers; both operands are already below SYMBOL_COUNT.
  function automatic logic [SW-1:0] add_mod(input logic [SW-1:0] a,
                                            input logic [SW-1:0] b);
    logic [SW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= SC_X) begin
      s = s - SC_X;
    end
    return s[SW-1:0];
  endfunction

  function automatic logic [SW-1:0] sub_mod(input logic [SW-1:0] a,
                                            input logic [SW-1:0] b);
    logic [SW:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + SC_X - {1'b0, b};
    end
    return s[SW-1:0];
  endfunction

  // Reduction of a raw start position, as a small constant table.
  function automatic logic [SW-1:0] mod_sym(input logic [SW-1:0] v);
    logic [SW-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << SW); i++) begin
      if (v == SW'(i)) begin
        r = SW'(i % SYMBOL_COUNT);
      end
    end
    return r;
  endfunction

  // Configuration registers. Start positions are stored already reduced.
  logic [2:0][SW-1:0]              start_r;
  logic [rct_pkg::THR_W-1:0]       thresh_r;

  // Live cipher state.
  logic [ROTOR_COUNT-1:0][SW-1:0]  off_r;
  logic [ROTOR_COUNT-1:0][SW-1:0]  off_nxt;
  logic [rct_pkg::POS_W-1:0]       pos_r;
  logic [rct_pkg::POS_W-1:0]       pos_nxt;

  // Pipeline: stage s reads the forward bank of rotor ROTOR_COUNT-1-s and the
  // inverse bank of rotor s. st_r/rd_r hold the item after stage s.
  logic [ROTOR_COUNT-1:0]          vld_r;
  stg_t                            st_r   [ROTOR_COUNT];
  logic [SW-1:0]                   rd_r   [ROTOR_COUNT];
  stg_t                            st_in  [ROTOR_COUNT];
  logic [SW-1:0]                   x_in   [ROTOR_COUNT];
  logic [ROTOR_COUNT:0]            mv;

  logic                            out_vld_r;
  logic [SW-1:0]                   out_sym_r;
  logic                            out_err_r;
  logic [SW-1:0]                   fin_sym;
  stg_t                            st0;
  logic                            in_take;

  // --------------------------------------------------------------------------
  // Handshake. Each stage moves when it holds an item and the stage after it
  // is empty or moving too, so bubbles close up and, until the stages fill, the
  // input keeps being taken while a finished result waits in the output register.
  // --------------------------------------------------------------------------
  always_comb begin
    mv[ROTOR_COUNT] = vld_r[ROTOR_COUNT-1] & (~out_vld_r | out_ch.ready);
    for (int s = ROTOR_COUNT - 1; s >= 1; s--) begin
      mv[s] = vld_r[s-1] & (~vld_r[s] | mv[s+1]);
    end
    mv[0] = in_ch.valid & (~vld_r[0] | mv[1]);
  end

  assign in_ch.ready = ~vld_r[0] | mv[1];
  assign in_take     = mv[0];

  // --------------------------------------------------------------------------
  // Front end: validation, position counting and rotor stepping happen when
  // the item is taken, which keeps the state in item order.
  // --------------------------------------------------------------------------
  always_comb begin
    logic                       cipher;
    logic                       bad_sym;
    logic [rct_pkg::POS_W-1:0]  p;
    logic [7:0]                 lim;

    cipher  = (in_ch.operation == rct_pkg::OP_ENCRYPT) ||
              (in_ch.operation == rct_pkg::OP_DECRYPT);
    bad_sym = (int'(in_ch.symbol) >= SYMBOL_COUNT);
    p       = in_ch.start_message ? '0 : pos_r;
    off_nxt = off_r;
    pos_nxt = pos_r;
    lim     = '0;

    unique case (in_ch.operation)
      rct_pkg::OP_ENCRYPT, rct_pkg::OP_DECRYPT: begin
        if (!bad_sym) begin
          // Rotor k steps once the position exceeds (ROTOR_COUNT-1-k) times
          // the threshold; the last rotor steps on every symbol.
          for (int k = 0; k < ROTOR_COUNT; k++) begin
            lim = 8'(ROTOR_COUNT - 1 - k) * {3'b000, thresh_r};
            if ((k == ROTOR_COUNT - 1) || ({1'b0, p} > lim)) begin
              off_nxt[k] = add_mod(off_r[k], SW'(1));
            end
          end
          pos_nxt = (p < rct_pkg::POS_MAX) ? p + 7'd1 : rct_pkg::POS_MAX;
        end
      end
      rct_pkg::OP_LOAD: begin
      end
      rct_pkg::OP_SET_POS: begin
        for (int k = 0; k < ROTOR_COUNT; k++) begin
          off_nxt[k] = (k < 3) ? start_r[k] : '0;
        end
        pos_nxt = '0;
      end
      default: begin
      end
    endcase

    st0.op    = in_ch.operation;
    st0.err   = cipher & bad_sym;
    st0.ld_ok = (int'(in_ch.rotor_select) < ROTOR_COUNT) &&
                (int'(in_ch.wiring_index) < SYMBOL_COUNT) &&
                (int'(in_ch.wiring_value) < SYMBOL_COUNT);
    st0.sel   = in_ch.rotor_select;
    st0.idx   = in_ch.wiring_index;
    st0.val   = in_ch.wiring_value;
    st0.off   = off_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r    <= '0;
      pos_r    <= '0;
      start_r  <= '0;
      thresh_r <= rct_pkg::THRESH_RESET;
    end else begin
      if (in_take) begin
        off_r <= off_nxt;
        pos_r <= pos_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          rct_pkg::CFG_START1: start_r[0] <= mod_sym(cfg_wdata);
          rct_pkg::CFG_START2: start_r[1] <= mod_sym(cfg_wdata);
          rct_pkg::CFG_START3: start_r[2] <= mod_sym(cfg_wdata);
          rct_pkg::CFG_THRESH: thresh_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Rotor stages. A wiring load is written into a bank when the load item
  // passes the stage that reads that bank: items ahead of it have already
  // read, items behind it will see the new entry.
  // --------------------------------------------------------------------------
  for (genvar s = 0; s < ROTOR_COUNT; s++) begin : g_stage
    logic [SW-1:0] fwd_bank [SYMBOL_COUNT];
    logic [SW-1:0] inv_bank [SYMBOL_COUNT];
    logic [SW-1:0] addr;

    if (s == 0) begin : g_first
      always_comb begin
        st_in[s] = st0;
        x_in[s]  = in_ch.symbol;
      end
    end else begin : g_next
      // Encrypt takes off the offset of the rotor read one stage back.
      always_comb begin
        st_in[s] = st_r[s-1];
        x_in[s]  = (st_r[s-1].op == rct_pkg::OP_ENCRYPT) ?
                   sub_mod(rd_r[s-1], st_r[s-1].off[ROTOR_COUNT-s]) : rd_r[s-1];
      end
    end

    // Decrypt adds this rotor's offset before the inverse lookup.
    assign addr = (st_in[s].op == rct_pkg::OP_DECRYPT) ?
                  add_mod(x_in[s], st_in[s].off[s]) : x_in[s];

    always_ff @(posedge clk) begin
      if (mv[s]) begin
        if ((st_in[s].op == rct_pkg::OP_LOAD) && st_in[s].ld_ok &&
            (int'(st_in[s].sel) == ROTOR_COUNT - 1 - s)) begin
          fwd_bank[st_in[s].idx[AW-1:0]] <= st_in[s].val;
        end
        if ((st_in[s].op == rct_pkg::OP_LOAD) && st_in[s].ld_ok &&
            (int'(st_in[s].sel) == s)) begin
          inv_bank[st_in[s].val[AW-1:0]] <= st_in[s].idx;
        end
        if (st_in[s].op == rct_pkg::OP_DECRYPT) begin
          rd_r[s] <= inv_bank[addr[AW-1:0]];
        end else begin
          rd_r[s] <= fwd_bank[addr[AW-1:0]];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int s = 0; s < ROTOR_COUNT; s++) begin
        if (mv[s]) begin
          vld_r[s] <= 1'b1;
        end else if (mv[s+1]) begin
          vld_r[s] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < ROTOR_COUNT; s++) begin
      if (mv[s]) begin
        st_r[s] <= st_in[s];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register. Encrypt finishes with rotor one's offset. Loads,
  // position sets and rejected symbols report symbol zero.
  // --------------------------------------------------------------------------
  always_comb begin
    fin_sym = '0;
    if (!st_r[ROTOR_COUNT-1].err) begin
      if (st_r[ROTOR_COUNT-1].op == rct_pkg::OP_ENCRYPT) begin
        fin_sym = sub_mod(rd_r[ROTOR_COUNT-1], st_r[ROTOR_COUNT-1].off[0]);
      end else if (st_r[ROTOR_COUNT-1].op == rct_pkg::OP_DECRYPT) begin
        fin_sym = rd_r[ROTOR_COUNT-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (mv[ROTOR_COUNT]) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mv[ROTOR_COUNT]) begin
      out_sym_r <= fin_sym;
      out_err_r <= st_r[ROTOR_COUNT-1].err;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.out_symbol = out_sym_r;
  assign out_ch.error      = out_err_r;

endmodule

`default_nettype wire
